// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hdl/etrs_pkg.sv -----
// Package with payload types and constants of the TRS matrix builder.
package etrs_pkg;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] position_z;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } etrs_in_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0_value;
        logic signed [31:0] col1_value;
        logic signed [31:0] col2_value;
        logic signed [31:0] col3_value;
        logic               last_row;
    } etrs_out_t;

    localparam int CORDIC_ITERS = 28;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [31:0] Q16_ONE     = 32'sh0001_0000;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] a;
        begin
            case (i)
                0:  a = 34'sh3243F6A8;
                1:  a = 34'sh1DAC6705;
                2:  a = 34'sh0FADBAFC;
                3:  a = 34'sh07F56EA6;
                4:  a = 34'sh03FEAB76;
                5:  a = 34'sh01FFD55B;
                6:  a = 34'sh00FFFAAA;
                7:  a = 34'sh007FFF55;
                8:  a = 34'sh003FFFEA;
                9:  a = 34'sh001FFFFD;
                10: a = 34'sh000FFFFF;
                11: a = 34'sh0007FFFF;
                12: a = 34'sh0003FFFF;
                13: a = 34'sh0001FFFF;
                14: a = 34'sh0000FFFF;
                15: a = 34'sh00007FFF;
                16: a = 34'sh00003FFF;
                17: a = 34'sh00001FFF;
                18: a = 34'sh00000FFF;
                19: a = 34'sh000007FF;
                20: a = 34'sh000003FF;
                21: a = 34'sh000001FF;
                22: a = 34'sh000000FF;
                23: a = 34'sh0000007F;
                24: a = 34'sh0000003F;
                25: a = 34'sh0000001F;
                26: a = 34'sh0000000F;
                27: a = 34'sh00000007;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

    // Q30 product, floored.
    function automatic logic signed [33:0] qmul(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [67:0] p;
        begin
            p = 68'(a) * 68'(b);
            return p[63:30];
        end
    endfunction

endpackage

// ----- hdl/etrs_cordic_lane.sv -----
// One pipelined CORDIC lane giving Q30 sine and cosine of a Q3.13 angle.
module etrs_cordic_lane (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output logic signed [33:0] sin_q30,
    output logic signed [33:0] cos_q30
);
    import etrs_pkg::*;

    localparam int N = CORDIC_ITERS;

    // Sincos magnitudes stay below 2^30, so 34 bits leave margin.
    logic signed [33:0] x_reg [0:N];
    logic signed [33:0] y_reg [0:N];
    logic signed [33:0] z_reg [0:N];
    logic               neg_reg [0:N];
    logic signed [33:0] z0_next;
    logic               neg_next;

    always_comb
    begin
        z0_next  = 34'(angle) <<< 17;
        neg_next = 1'b0;
        if (z0_next > HALF_PI_Q30)
        begin
            z0_next  = z0_next - PI_Q30;
            neg_next = 1'b1;
        end
        else if (z0_next < -HALF_PI_Q30)
        begin
            z0_next  = z0_next + PI_Q30;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= z0_next;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][33])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
            end
        end
    end

    assign sin_q30 = neg_reg[N] ? -y_reg[N] : y_reg[N];
    assign cos_q30 = neg_reg[N] ? -x_reg[N] : x_reg[N];

endmodule

// ----- hdl/etrs_merge.sv -----
// Merging stage: rotation terms from the three lanes, scaled and saturated.
module etrs_merge (
    input  logic               clk,
    input  logic               en,
    input  logic signed [33:0] sx,
    input  logic signed [33:0] cx,
    input  logic signed [33:0] sy,
    input  logic signed [33:0] cy,
    input  logic signed [33:0] sz,
    input  logic signed [33:0] cz,
    input  etrs_pkg::etrs_in_t item_in,
    output etrs_pkg::etrs_out_t rows [0:2]
);
    import etrs_pkg::*;

    // Stage A: two-factor products.
    logic signed [33:0] czcy_reg, czsy_reg, szcx_reg, szsx_reg, szcy_reg;
    logic signed [33:0] szsy_reg, czcx_reg, czsx_reg, cysx_reg, cycx_reg;
    logic signed [33:0] nsy_reg, sxa_reg, cxa_reg;
    etrs_in_t           ia_reg;
    // Stage B: full rotation terms.
    logic signed [33:0] r_reg [0:2][0:2];
    etrs_in_t           ib_reg;
    // Stage C: scaled products.
    logic signed [66:0] p_reg [0:2][0:2];
    etrs_in_t           ic_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            czcy_reg <= qmul(cz, cy);
            czsy_reg <= qmul(cz, sy);
            szcx_reg <= qmul(sz, cx);
            szsx_reg <= qmul(sz, sx);
            szcy_reg <= qmul(sz, cy);
            szsy_reg <= qmul(sz, sy);
            czcx_reg <= qmul(cz, cx);
            czsx_reg <= qmul(cz, sx);
            cysx_reg <= qmul(cy, sx);
            cycx_reg <= qmul(cy, cx);
            nsy_reg  <= -sy;
            sxa_reg  <= sx;
            cxa_reg  <= cx;
            ia_reg   <= item_in;

            r_reg[0][0] <= czcy_reg;
            r_reg[0][1] <= qmul(czsy_reg, sxa_reg) - szcx_reg;
            r_reg[0][2] <= qmul(czsy_reg, cxa_reg) + szsx_reg;
            r_reg[1][0] <= szcy_reg;
            r_reg[1][1] <= qmul(szsy_reg, sxa_reg) + czcx_reg;
            r_reg[1][2] <= qmul(szsy_reg, cxa_reg) - czsx_reg;
            r_reg[2][0] <= nsy_reg;
            r_reg[2][1] <= cysx_reg;
            r_reg[2][2] <= cycx_reg;
            ib_reg      <= ia_reg;

            for (int k = 0; k < 3; k++)
            begin
                p_reg[k][0] <= 67'(r_reg[k][0]) * 67'(ib_reg.scale_x) + 67'sd536870912;
                p_reg[k][1] <= 67'(r_reg[k][1]) * 67'(ib_reg.scale_y) + 67'sd536870912;
                p_reg[k][2] <= 67'(r_reg[k][2]) * 67'(ib_reg.scale_z) + 67'sd536870912;
            end
            ic_reg <= ib_reg;
        end
    end

    function automatic logic signed [31:0] sat(input logic signed [66:0] p);
        logic signed [36:0] v;
        begin
            v = p[66:30];
            if (v > 37'sd2147483647)
                return 32'sh7FFFFFFF;
            else if (v < -37'sd2147483648)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rows[k].row_index  = 2'(k);
            rows[k].col0_value = sat(p_reg[k][0]);
            rows[k].col1_value = sat(p_reg[k][1]);
            rows[k].col2_value = sat(p_reg[k][2]);
            rows[k].last_row   = 1'b0;
        end
        rows[0].col3_value = ic_reg.position_x;
        rows[1].col3_value = ic_reg.position_y;
        rows[2].col3_value = ic_reg.position_z;
    end

endmodule

// ----- hdl/euler_trs_matrix_builder.sv -----
// Top level of the Euler TRS model-matrix builder.
//
// The in channel (in_valid, in_ready, in_data) takes one item: position,
// three Q3.13 Euler angles and a per-axis scale. The out channel
// (out_valid, out_ready, out_data) returns four row items for each input
// item, row 0 first; last_row marks row 3, which is always 0,0,0,1.0.
// Three CORDIC lanes, one per angle, run side by side as 29-stage
// pipelines; a three-stage merging unit forms the Z*Y*X rotation, scales
// its columns and saturates. Row 0 is offered once the item has passed the
// lane and merging registers and been loaded into the row sequencer. The
// pipeline advances only when its last stage is empty or being unloaded
// into the row sequencer, so a stalled receiver freezes the whole
// pipeline and no item is lost. The sequencer sends one row per cycle
// while out_ready is high, so the single result channel limits throughput
// to one item per four rows. Reset empties the pipeline and the sequencer.
module euler_trs_matrix_builder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  etrs_pkg::etrs_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output etrs_pkg::etrs_out_t out_data
);
    import etrs_pkg::*;
`include "assert_macros.svh"

    localparam int DEPTH = CORDIC_ITERS + 4;

    logic               en;
    logic [DEPTH-1:0]   vld_reg;
    etrs_in_t           hold_reg [0:CORDIC_ITERS];
    logic signed [33:0] sx, cx, sy, cy, sz, cz;
    etrs_out_t          rows [0:2];
    etrs_out_t          rows_reg [0:2];
    logic [1:0]         row_reg;
    logic               busy_reg;
    logic               load;

    // The sequencer can take a new matrix when idle or when its last row is taken.
    assign load = !busy_reg || (out_ready && row_reg == 2'd3);
    assign en   = !vld_reg[DEPTH-1] || load;
    assign in_ready = en;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hold_reg[0] <= in_data;
            for (int i = 1; i <= CORDIC_ITERS; i++)
                hold_reg[i] <= hold_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    etrs_cordic_lane u_lane_x (.clk, .en, .angle(in_data.angle_x),
                               .sin_q30(sx), .cos_q30(cx));
    etrs_cordic_lane u_lane_y (.clk, .en, .angle(in_data.angle_y),
                               .sin_q30(sy), .cos_q30(cy));
    etrs_cordic_lane u_lane_z (.clk, .en, .angle(in_data.angle_z),
                               .sin_q30(sz), .cos_q30(cz));

    etrs_merge u_merge (.clk, .en, .sx, .cx, .sy, .cy, .sz, .cz,
                        .item_in(hold_reg[CORDIC_ITERS]), .rows);

    always_ff @(posedge clk)
    begin
        if (load && vld_reg[DEPTH-1])
            rows_reg <= rows;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= vld_reg[DEPTH-1];
            row_reg  <= '0;
        end
        else if (out_ready)
            row_reg <= row_reg + 2'd1;
    end

    always_comb
    begin
        out_valid = busy_reg;
        case (row_reg)
            2'd0: out_data = rows_reg[0];
            2'd1: out_data = rows_reg[1];
            2'd2: out_data = rows_reg[2];
            2'd3:
            begin
                out_data.row_index  = 2'd3;
                out_data.col0_value = '0;
                out_data.col1_value = '0;
                out_data.col2_value = '0;
                out_data.col3_value = Q16_ONE;
                out_data.last_row   = 1'b1;
            end
            default: out_data = rows_reg[0];
        endcase
    end

    `ASSERT_IMPL(a_last_row, clk, rst_n, out_valid, out_data.last_row == (row_reg == 2'd3))
    `ASSERT_NEXT(a_row_hold, clk, rst_n, out_valid && !out_ready, $stable(row_reg) && out_valid)
    `ASSERT_IMPL(a_no_drop, clk, rst_n, vld_reg[DEPTH-1] && !en, busy_reg)

endmodule

// ----- test/tb.sv -----
// Testbench of the Euler TRS model-matrix builder: predicted rows checked against the block.
`timescale 1ns / 100ps

// Scoreboard: predicts the four rows of each accepted item and checks every result row.
class matrix_scoreboard;
    etrs_pkg::etrs_out_t rows_due[$];
    int errors;
    int rows_checked;

    function new();
        errors = 0;
        rows_checked = 0;
    endfunction

    static function longint q30_product(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    static function void cordic_sincos(logic signed [15:0] ang, output longint s,
                                       output longint c);
        longint z, x, y, dx, dy;
        bit flip;
        longint atans[28];
        atans = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
                  32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
                  32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
                  32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
                  32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
                  32'h0000001F, 32'h0000000F, 32'h00000007};
        z = longint'(ang) * 131072;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 64'sd1686629713)
        begin
            z -= 64'sd3373259426;
            flip = 1;
        end
        else if (z < -64'sd1686629713)
        begin
            z += 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < 28; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atans[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atans[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    static function logic [31:0] scale_entry(longint r, longint scl);
        longint v;
        v = (r * scl + (64'sd1 << 29)) >>> 30;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function void note_item(etrs_pkg::etrs_in_t it);
        longint sx, cx, sy, cy, sz, cz;
        longint rot[3][3];
        longint scl[3];
        longint pos[3];
        etrs_pkg::etrs_out_t row;
        cordic_sincos(it.angle_x, sx, cx);
        cordic_sincos(it.angle_y, sy, cy);
        cordic_sincos(it.angle_z, sz, cz);
        rot[0][0] = q30_product(cz, cy);
        rot[0][1] = q30_product(q30_product(cz, sy), sx) - q30_product(sz, cx);
        rot[0][2] = q30_product(q30_product(cz, sy), cx) + q30_product(sz, sx);
        rot[1][0] = q30_product(sz, cy);
        rot[1][1] = q30_product(q30_product(sz, sy), sx) + q30_product(cz, cx);
        rot[1][2] = q30_product(q30_product(sz, sy), cx) - q30_product(cz, sx);
        rot[2][0] = -sy;
        rot[2][1] = q30_product(cy, sx);
        rot[2][2] = q30_product(cy, cx);
        scl[0] = it.scale_x;
        scl[1] = it.scale_y;
        scl[2] = it.scale_z;
        pos[0] = it.position_x;
        pos[1] = it.position_y;
        pos[2] = it.position_z;
        for (int k = 0; k < 3; k++)
        begin
            row.row_index = 2'(k);
            row.col0_value = scale_entry(rot[k][0], scl[0]);
            row.col1_value = scale_entry(rot[k][1], scl[1]);
            row.col2_value = scale_entry(rot[k][2], scl[2]);
            row.col3_value = pos[k][31:0];
            row.last_row = 1'b0;
            rows_due.push_back(row);
        end
        row = '0;
        row.row_index = 2'd3;
        row.col3_value = etrs_pkg::Q16_ONE;
        row.last_row = 1'b1;
        rows_due.push_back(row);
    endfunction

    function void check_row(etrs_pkg::etrs_out_t got);
        etrs_pkg::etrs_out_t want;
        rows_checked++;
        if (rows_due.size() == 0)
        begin
            $display("%0t: unexpected row, got %h", $time, got);
            errors++;
            return;
        end
        want = rows_due.pop_front();
        if (got.row_index !== want.row_index)
        begin
            $display("%0t: row_index expected %0d actual %0d", $time, want.row_index,
                     got.row_index);
            errors++;
        end
        if (got.col0_value !== want.col0_value)
        begin
            $display("%0t: col0 expected %h actual %h", $time, want.col0_value,
                     got.col0_value);
            errors++;
        end
        if (got.col1_value !== want.col1_value)
        begin
            $display("%0t: col1 expected %h actual %h", $time, want.col1_value,
                     got.col1_value);
            errors++;
        end
        if (got.col2_value !== want.col2_value)
        begin
            $display("%0t: col2 expected %h actual %h", $time, want.col2_value,
                     got.col2_value);
            errors++;
        end
        if (got.col3_value !== want.col3_value)
        begin
            $display("%0t: col3 expected %h actual %h", $time, want.col3_value,
                     got.col3_value);
            errors++;
        end
        if (got.last_row !== want.last_row)
        begin
            $display("%0t: last_row expected %b actual %b", $time, want.last_row,
                     got.last_row);
            errors++;
        end
    endfunction
endclass

module tb;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    etrs_pkg::etrs_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    etrs_pkg::etrs_out_t out_data;

    // Idle percentages of the two sides; changed between the phases.
    int send_idle_pct = 35;
    int recv_idle_pct = 52;
    int items_sent = 0;
    matrix_scoreboard board = new();

    euler_trs_matrix_builder DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always #5 clk = ~clk;

    // Receiver: ready is redrawn at every falling edge, and a row is taken at the
    // rising edge where valid and ready are both high.
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_row(out_data);
    end

    // Offer one item; it is held until the block accepts it. The idle gap comes
    // first so that valid never drops between two back-to-back items.
    task automatic send_item(etrs_pkg::etrs_in_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    // Angles mostly inside plus or minus pi, sometimes any 16-bit pattern.
    function automatic logic [15:0] draw_angle();
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(51472)) - 25736);
    endfunction

    // Scales mostly within plus or minus 4.0 or 512.0 in Q16.16, sometimes full range to drive saturation.
    function automatic logic [31:0] draw_scale();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
            default: return 32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
        endcase
    endfunction

    function automatic etrs_pkg::etrs_in_t random_item();
        etrs_pkg::etrs_in_t it;
        it.position_x = $urandom;
        it.position_y = $urandom;
        it.position_z = $urandom;
        it.angle_x = draw_angle();
        it.angle_y = draw_angle();
        it.angle_z = draw_angle();
        it.scale_x = draw_scale();
        it.scale_y = draw_scale();
        it.scale_z = draw_scale();
        return it;
    endfunction

    function automatic etrs_pkg::etrs_in_t uniform_item(logic signed [15:0] ang,
                                                       logic signed [31:0] scl,
                                                       logic signed [31:0] pos);
        etrs_pkg::etrs_in_t it;
        it.position_x = pos;
        it.position_y = -pos;
        it.position_z = pos;
        it.angle_x = ang;
        it.angle_y = ang;
        it.angle_z = ang;
        it.scale_x = scl;
        it.scale_y = scl;
        it.scale_z = scl;
        return it;
    endfunction

    task automatic run_phase(int n);
        for (int i = 0; i < n; i++)
            send_item(random_item());
    endtask

    initial
    begin
        etrs_pkg::etrs_in_t it;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: identity, extremes of angle (inside and beyond pi), zero and
        // full-scale scales to force saturation both ways, extremes of position.
        send_item(uniform_item(16'sd0, 32'sh0001_0000, 32'sd0));
        send_item(uniform_item(16'sd25736, 32'sh0001_0000, 32'sh7FFF_FFFF));
        send_item(uniform_item(-16'sd25736, 32'sh0001_0000, 32'sh8000_0000));
        send_item(uniform_item(16'sd12868, 32'sh0001_0000, 32'sd1));
        send_item(uniform_item(-16'sd12868, 32'sh0001_0000, -32'sd1));
        send_item(uniform_item(16'sd12869, 32'sh0002_0000, 32'sd0));
        send_item(uniform_item(-16'sd12869, 32'sh0002_0000, 32'sd0));
        send_item(uniform_item(16'sh7FFF, 32'sh7FFF_FFFF, 32'sd0));
        send_item(uniform_item(16'sh8000, 32'sh8000_0000, 32'sd0));
        send_item(uniform_item(16'sh5555, 32'sh7FFF_FFFF, 32'sh5555_5555));
        send_item(uniform_item(16'shAAAA, 32'sh8000_0000, 32'shAAAA_AAAA));
        send_item(uniform_item(16'sd6434, 32'sd0, 32'sd0));
        send_item(uniform_item(-16'sd6434, 32'shFFFF_FFFF, 32'sd0));
        send_item(uniform_item(16'sd100, 32'sd1, 32'sd0));
        send_item(uniform_item(16'shFFFF, 32'sh0000_FFFF, 32'shFFFF_0000));
        it = uniform_item(16'sd0, 32'sh7FFF_FFFF, 32'sd0);
        it.angle_z = 16'sd25736;
        it.scale_y = 32'sh8000_0000;
        send_item(it);

        run_phase(110);
        send_idle_pct = 52;
        recv_idle_pct = 35;
        run_phase(110);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(110);
        in_valid <= 1'b0;

        while (board.rows_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d items and %0d rows: angle and scale extremes, saturation,",
                 items_sent, board.rows_checked);
        $display("and three idling patterns on both channels.");
        if (board.errors == 0)
            $display("PASS euler_trs_matrix_builder");
        else
            $display("FAIL euler_trs_matrix_builder");
        $finish;
    end

    // Watchdog far above the slowest legal run.
    initial
    begin
        #2000000;
        $display("FAIL euler_trs_matrix_builder");
        $finish;
    end
endmodule

// ----- euler_trs_matrix_builder.f -----
+incdir+hdl
hdl/etrs_pkg.sv
hdl/etrs_cordic_lane.sv
hdl/etrs_merge.sv
hdl/euler_trs_matrix_builder.sv
test/tb.sv
